FILE: src/sha1_hash_engine_top_assert.svh
// assertion macros for the sha1 engine
`ifndef SHA1_HASH_ENGINE_TOP_ASSERT_SVH
`define SHA1_HASH_ENGINE_TOP_ASSERT_SVH
// implication checked every edge outside reset
`define SHA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication outside reset
`define SHA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: src/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// shared types, constants and round functions of the sha1 engine
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hefcdab89;
  localparam logic [31:0] H2 = 32'h98badcfe;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hc3d2e1f0;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  // classified transaction passed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } cmd_t;

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20)      f = (b & c) | (~b & d);
    else if (r < 7'd40) f = b ^ c ^ d;
    else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
    else                f = b ^ c ^ d;
    return f;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20)      k = K0;
    else if (r < 7'd40) k = K1;
    else if (r < 7'd60) k = K2;
    else                k = K3;
    return k;
  endfunction

endpackage

FILE: src/sha1_front.sv
// ----------------------------------------------------------------------------
// sha1_front
// input stage and command queue; drops items that carry nothing
// ----------------------------------------------------------------------------
module sha1_front #(
  parameter int DEPTH = sha1_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     data_byte,
  input  logic           has_byte,
  input  logic           last_byte,
  output logic           cmd_valid,
  input  logic           cmd_take,
  output sha1_pkg::cmd_t cmd
);
  import sha1_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t           mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;
  logic           push;
  logic           pop;
  logic           accept;

  assign in_stall  = (count == (AW+1)'(DEPTH));
  assign accept    = in_valid && !in_stall;
  // items with neither byte nor last are dropped here
  assign push      = accept && (has_byte || last_byte);
  assign cmd_valid = (count != '0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{data: data_byte, has_byte: has_byte, last: last_byte};
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

FILE: src/sha1_back.sv
// ----------------------------------------------------------------------------
// sha1_back
// block buffer, padding sequencer, round unit and digest output
// ----------------------------------------------------------------------------
module sha1_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_take,
  input  sha1_pkg::cmd_t cmd,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [31:0]    digest_word,
  output logic [2:0]     word_index,
  output logic           last_word
);
  import sha1_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_LOAD  = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_ADD   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t       state;
  logic [31:0]  chain [5];
  logic [31:0]  blk [16];
  logic [31:0]  wq [16];
  logic [31:0]  a, b, c, d, e;
  logic [5:0]   fill;
  logic [5:0]   fill_after;
  logic [60:0]  msg_bytes;
  logic [6:0]   rnd;
  logic         msg_end;
  logic         pad_done;
  logic         len_blk;
  logic [2:0]   oidx;
  logic [31:0]  rd_word;
  logic [3:0]   rd_sel;
  logic [7:0]   wr_data;
  logic         wr_en;
  logic [63:0]  bits;
  logic [31:0]  w_cur;
  logic [31:0]  w_new;
  logic [31:0]  t;

  assign bits       = {msg_bytes, 3'b000};
  assign fill_after = cmd.has_byte ? fill + 6'd1 : fill;

  // byte source: message byte, then 0x80, zeros and the bit length
  always_comb begin
    wr_en   = 1'b0;
    wr_data = cmd.data;
    if (state == ST_IDLE && cmd_valid && cmd.has_byte) begin
      wr_en = 1'b1;
    end else if (state == ST_PAD) begin
      wr_en = 1'b1;
      if (!pad_done)                      wr_data = PAD_BYTE;
      else if (len_blk && fill >= 6'd56)  wr_data = bits[{~fill[2:0], 3'b000} +: 8];
      else                                wr_data = 8'h00;
    end
  end

  // byte lane write into the word-wide block buffer, big-endian
  always_ff @(posedge clk) begin
    if (wr_en) blk[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= wr_data;
  end

  // registered word read for the first sixteen rounds
  assign rd_sel = (state == ST_ROUND) ? rnd[3:0] + 4'd1 : 4'd0;

  always_ff @(posedge clk) begin
    rd_word <= blk[rd_sel];
  end

  assign cmd_take = (state == ST_IDLE) && cmd_valid;
  assign w_cur = (rnd < 7'd16) ? rd_word : w_new;
  assign w_new = {wq[13] ^ wq[8] ^ wq[2] ^ wq[0]} << 1 |
                 {31'd0, wq[13][31] ^ wq[8][31] ^ wq[2][31] ^ wq[0][31]};
  assign t = {a[26:0], a[31:27]} + round_f(rnd, b, c, d) + e + round_k(rnd) + w_cur;

  assign out_valid   = (state == ST_OUT);
  assign digest_word = chain[oidx];
  assign word_index  = oidx;
  assign last_word   = (oidx == 3'd4);

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      msg_bytes <= '0;
      rnd       <= '0;
      msg_end   <= 1'b0;
      pad_done  <= 1'b0;
      len_blk   <= 1'b0;
      oidx      <= '0;
      chain     <= '{H0, H1, H2, H3, H4};
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            if (cmd.has_byte) msg_bytes <= msg_bytes + 61'd1;
            fill <= fill_after;
            if (cmd.has_byte && fill == 6'd63) begin
              // block full: compress, padding follows when this ends the message
              state    <= ST_LOAD;
              msg_end  <= cmd.last;
              pad_done <= 1'b0;
              len_blk  <= 1'b0;
            end else if (cmd.last) begin
              state    <= ST_PAD;
              msg_end  <= 1'b1;
              pad_done <= 1'b0;
              len_blk  <= (fill_after < 6'd56);
            end
          end
        end
        ST_PAD: begin
          pad_done <= 1'b1;
          fill     <= fill + 6'd1;
          if (fill == 6'd63) state <= ST_LOAD;
        end
        ST_LOAD: begin
          state <= ST_ROUND;
          rnd   <= '0;
          a <= chain[0]; b <= chain[1]; c <= chain[2]; d <= chain[3]; e <= chain[4];
        end
        ST_ROUND: begin
          e <= d; d <= c; c <= {b[1:0], b[31:2]}; b <= a; a <= t;
          for (int i = 0; i < 15; i++) wq[i] <= wq[i+1];
          wq[15] <= w_cur;
          rnd <= rnd + 7'd1;
          if (rnd == 7'd79) state <= ST_ADD;
        end
        ST_ADD: begin
          chain[0] <= chain[0] + a; chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c; chain[3] <= chain[3] + d;
          chain[4] <= chain[4] + e;
          if (msg_end && len_blk) begin
            state <= ST_OUT;
            oidx  <= '0;
          end else if (msg_end) begin
            // length did not fit: one more padding block
            state   <= ST_PAD;
            len_blk <= 1'b1;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd4) begin
              state     <= ST_IDLE;
              msg_bytes <= '0;
              fill      <= '0;
              msg_end   <= 1'b0;
              pad_done  <= 1'b0;
              len_blk   <= 1'b0;
              chain     <= '{H0, H1, H2, H3, H4};
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `include "sha1_hash_engine_top_assert.svh"
  `SHA_ASSERT_IMPL(a_take_idle, cmd_take, state == ST_IDLE)
  `SHA_ASSERT_IMPL(a_out_idx, out_valid, oidx <= 3'd4)
  `SHA_ASSERT_NEXT(a_round_end, state == ST_ROUND && rnd == 7'd79, state == ST_ADD)

endmodule

FILE: src/sha1_hash_engine_top.sv
// a byte that completes a block starts a compression: load, 80 rounds, add
// other bytes only fill the buffer; no byte is taken during padding, compression or digest output
// last item: padding sweep to the end of the block plus one or two compressions, then 5 words
// rate is set by the single shared round unit, one round per cycle
// rst is synchronous, active high; it restores the initial chaining words
// ----------------------------------------------------------------------------
// sha1_hash_engine_top
// streaming sha1 engine: input queue front, compression back
// ----------------------------------------------------------------------------
module sha1_hash_engine_top #(
  parameter int QUEUE_DEPTH = sha1_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha1_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;

  // front: accept and queue transactions
  sha1_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk, .rst, .in_valid, .in_stall, .data_byte, .has_byte, .last_byte,
    .cmd_valid, .cmd_take, .cmd
  );

  // back: compression and digest output
  sha1_back u_back (
    .clk, .rst, .cmd_valid, .cmd_take, .cmd,
    .out_valid, .out_stall, .digest_word, .word_index, .last_word
  );

endmodule

FILE: tb/sha1_hash_engine_top_tb.sv
// ----------------------------------------------------------------------------
// sha1_hash_engine_top_tb
// streams byte messages into the sha1 engine, predicts each digest and checks
// every digest word; random idling on both sides plus a long receiver hold-off
// ----------------------------------------------------------------------------
module sha1_hash_engine_top_tb;
  import sha1_pkg::*;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_exp_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        has_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  // predictor state
  logic [31:0] chain_q [5];
  logic [7:0]  blk_q [64];
  int          fill_q;
  logic [60:0] msg_len_q;

  digest_exp_t digest_fifo [$];
  int          fail_cnt;
  int          idle_cnt;
  bit          rx_idle_en;
  bit          tx_idle_en;
  bit          rx_hold;

  sha1_hash_engine_top uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .has_byte(has_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall), .digest_word(digest_word),
    .word_index(word_index), .last_word(last_word)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // 80-round compression over the buffered block
  task automatic sha_compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_q[4*i], blk_q[4*i+1], blk_q[4*i+2], blk_q[4*i+3]};
    for (int i = 16; i < 80; i++)
      w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3]; e = chain_q[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = K0;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = K2;
      end else begin
        f = b ^ c ^ d; k = K3;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d; chain_q[4] += e;
  endtask

  task automatic sha_init();
    chain_q[0] = H0; chain_q[1] = H1; chain_q[2] = H2; chain_q[3] = H3; chain_q[4] = H4;
    fill_q = 0;
    msg_len_q = '0;
  endtask

  // predict one accepted transaction
  task automatic sha_predict(input logic [7:0] db, input logic hb, input logic lb);
    logic [63:0] bits;
    int pos;
    digest_exp_t ex;
    if (hb) begin
      blk_q[fill_q] = db;
      fill_q++;
      msg_len_q++;
      if (fill_q == 64) begin
        sha_compress();
        fill_q = 0;
      end
    end
    if (lb) begin
      bits = {msg_len_q, 3'b000};
      pos = fill_q;
      blk_q[pos++] = PAD_BYTE;
      if (pos > 56) begin
        while (pos < 64) blk_q[pos++] = 8'h00;
        sha_compress();
        pos = 0;
      end
      while (pos < 56) blk_q[pos++] = 8'h00;
      for (int i = 0; i < 8; i++) blk_q[56+i] = bits[63-8*i -: 8];
      sha_compress();
      for (int i = 0; i < 5; i++) begin
        ex.word = chain_q[i];
        ex.index = 3'(i);
        ex.last = (i == 4);
        digest_fifo = {digest_fifo, ex};
      end
      sha_init();
    end
  endtask

  // offer one transaction and wait for acceptance
  task automatic send_item(input logic [7:0] db, input logic hb, input logic lb);
    while (tx_idle_en && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= db;
    has_byte  <= hb;
    last_byte <= lb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sha_predict(db, hb, lb);
  endtask

  task automatic send_msg(input int len);
    for (int i = 0; i < len; i++) send_item(8'($urandom), 1'b1, 1'b0);
    send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (digest_fifo.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // receiver stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= rx_hold || (rx_idle_en && $urandom_range(99) < 8);
    end
  end

  // digest word checker
  always @(posedge clk) begin
    digest_exp_t ex;
    if (!rst && out_valid && !out_stall) begin
      if (digest_fifo.size() == 0) begin
        $error("unexpected digest word %h", digest_word);
        fail_cnt++;
      end else begin
        ex = digest_fifo.pop_front();
        if (digest_word !== ex.word) begin
          $error("digest_word exp %h got %h", ex.word, digest_word); fail_cnt++;
        end
        if (word_index !== ex.index) begin
          $error("word_index exp %0d got %0d", ex.index, word_index); fail_cnt++;
        end
        if (last_word !== ex.last) begin
          $error("last_word exp %0d got %0d", ex.last, last_word); fail_cnt++;
        end
      end
    end
  end

  // watchdog on transaction-free cycles
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > 20000) begin
      $display("[sha1_hash_engine_top] ERROR");
      $finish;
    end
  end

  // directed: empty, single-byte extremes, a short message with empty items between bytes
  task automatic test_directed();
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    drain();
  endtask

  // block-boundary messages back to back, no idling on either side
  task automatic test_boundaries();
    int lens [4] = '{55, 56, 63, 64};
    rx_idle_en = 1'b0;
    tx_idle_en = 1'b0;
    foreach (lens[i]) send_msg(lens[i]);
    // last transaction carries the byte that completes a block
    for (int i = 0; i < 63; i++) send_item(8'($urandom), 1'b1, 1'b0);
    send_item(8'($urandom), 1'b1, 1'b1);
    drain();
    rx_idle_en = 1'b1;
    tx_idle_en = 1'b1;
  endtask

  // receiver held off while the sender keeps offering
  task automatic test_backpressure();
    rx_hold = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        rx_hold = 1'b0;
      end
      begin
        send_msg(3); send_msg(0); send_msg(5);
      end
    join
    drain();
  endtask

  task automatic test_random();
    int len;
    for (int m = 0; m < 6; m++) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(70, 64) : $urandom_range(12);
      for (int i = 0; i < len; i++)
        send_item(8'($urandom), 1'b1, 1'b0);
      if ($urandom_range(3) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'($urandom), 1'b1);
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    has_byte = 1'b0;
    last_byte = 1'b0;
    fail_cnt = 0;
    rx_idle_en = 1'b1;
    tx_idle_en = 1'b1;
    rx_hold = 1'b0;
    sha_init();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_boundaries();
    test_backpressure();
    test_random();
    if (fail_cnt == 0) $display("[sha1_hash_engine_top] OK");
    else $display("[sha1_hash_engine_top] ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/sha1_pkg.sv
src/sha1_front.sv
src/sha1_back.sv
src/sha1_hash_engine_top.sv
tb/sha1_hash_engine_top_tb.sv
